### hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types for the exponentiation sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Configuration register indexes.
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	// Top-level sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DONE
	} mexp_state_t;

	// Modular multiplier states.
	typedef enum logic [1:0] {
		MS_IDLE,
		MS_DBL,
		MS_ADD
	} mexp_mul_state_t;

	// Status returned by the modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_stat_t;

endpackage

### hdl/mexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative modular multiplier
// Computes a * b mod m by shift-and-add over the bits of b, most significant
// first, with one modular addition per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] a,
	input  logic [OPERAND_BITS-1:0] b,
	input  logic [OPERAND_BITS-1:0] m,
	output mexp_mul_stat_t          stat,
	output logic [OPERAND_BITS-1:0] product
);

	localparam int CNT_W = $clog2(OPERAND_BITS);

	mexp_mul_state_t         state_q, state_d;
	logic [OPERAND_BITS-1:0] acc_q, a_q, b_q, m_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [OPERAND_BITS-1:0] addend;
	logic                    step_end;
	logic                    last;
	logic [OPERAND_BITS:0]   sum;
	logic [OPERAND_BITS:0]   diff;
	logic [OPERAND_BITS-1:0] acc_next;

	// Both operands of the addition are below m, so one conditional
	// subtraction brings the sum back into range.
	assign sum      = {1'b0, acc_q} + {1'b0, addend};
	assign diff     = sum - {1'b0, m_q};
	assign acc_next = (sum >= {1'b0, m_q}) ? diff[OPERAND_BITS-1:0] : sum[OPERAND_BITS-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			MS_IDLE: begin
				if (start) state_d = MS_DBL;
			end
			MS_DBL: begin
				if (b_q[OPERAND_BITS-1]) state_d = MS_ADD;
				else if (cnt_q == '0)    state_d = MS_IDLE;
			end
			MS_ADD: begin
				state_d = (cnt_q == '0) ? MS_IDLE : MS_DBL;
			end
			default: state_d = MS_IDLE;
		endcase
	end

	always_comb begin
		addend   = (state_q == MS_ADD) ? a_q : acc_q;
		step_end = (state_q == MS_ADD) || (state_q == MS_DBL && !b_q[OPERAND_BITS-1]);
		last     = step_end && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_IDLE && start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			cnt_q <= CNT_W'(OPERAND_BITS - 1);
		end else if (state_q != MS_IDLE) begin
			acc_q <= acc_next;
			if (step_end) begin
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign stat.busy = (state_q != MS_IDLE);
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

### hdl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each base to the configured exponent modulo the configured modulus
// by left-to-right square-and-multiply on one shared modular multiplier.
// ----------------------------------------------------------------------------
// A base is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on power_mod for one
// cycle with done high and must be captured then, as it cannot be held off.
// Every product goes through one iterative multiplier that doubles once per
// multiplier bit and adds once per set bit. The base is first reduced with
// one multiply, then each exponent bit costs a squaring and, if set, a
// further multiply.
// Configuration writes are only to be made while busy is low.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OPERAND_BITS-1:0] base,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] power_mod,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [OPERAND_BITS-1:0] wr_data
);

	localparam int CNT_W = $clog2(OPERAND_BITS);
	localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

	mexp_state_t             state_q, state_d;
	logic [OPERAND_BITS-1:0] exponent_q, modulus_q;
	logic [OPERAND_BITS-1:0] m_eff;
	logic [OPERAND_BITS-1:0] acc_q, base_q, e_q;
	logic [CNT_W-1:0]        ecnt_q;
	logic                    mul_start;
	logic [OPERAND_BITS-1:0] mul_b;
	logic [OPERAND_BITS-1:0] product;
	mexp_mul_stat_t          mul_stat;
	logic                    bit_end;

	// A modulus of zero behaves as a modulus of one.
	assign m_eff = (modulus_q == '0) ? ONE : modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= ONE;
			modulus_q  <= ONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_EXPONENT: exponent_q <= wr_data;
				REG_MODULUS:  modulus_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign bit_end = mul_stat.done &&
		((state_q == ST_SQ_WAIT && !e_q[OPERAND_BITS-1]) || state_q == ST_MUL_WAIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_RED_GO;
			ST_RED_GO:   state_d = ST_RED_WAIT;
			ST_RED_WAIT: if (mul_stat.done) state_d = ST_SQ_GO;
			ST_SQ_GO:    state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (mul_stat.done) begin
					if (e_q[OPERAND_BITS-1]) state_d = ST_MUL_GO;
					else state_d = (ecnt_q == '0) ? ST_DONE : ST_SQ_GO;
				end
			end
			ST_MUL_GO:   state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mul_stat.done) state_d = (ecnt_q == '0) ? ST_DONE : ST_SQ_GO;
			end
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// The multiplicand is always the running accumulator; only the
	// multiplier changes between reduction, squaring and multiplication.
	always_comb begin
		mul_start = (state_q == ST_RED_GO) || (state_q == ST_SQ_GO) || (state_q == ST_MUL_GO);
		mul_b     = (state_q == ST_SQ_GO) ? acc_q : base_q;
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		power_mod = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			base_q <= base;
			acc_q  <= (m_eff == ONE) ? '0 : ONE;
			e_q    <= exponent_q;
			ecnt_q <= CNT_W'(OPERAND_BITS - 1);
		end else begin
			// Reducing the base is a multiply of (1 mod m) by the raw base.
			if (state_q == ST_RED_WAIT && mul_stat.done) base_q <= product;
			if ((state_q == ST_SQ_WAIT || state_q == ST_MUL_WAIT) && mul_stat.done) begin
				acc_q <= product;
			end
			if (bit_end) begin
				e_q    <= e_q << 1;
				ecnt_q <= ecnt_q - 1'b1;
			end
		end
	end

	mexp_mulmod #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      (mul_b),
		.m      (m_eff),
		.stat   (mul_stat),
		.product(product)
	);

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (power_mod < m_eff))
		else $error("result beat not reduced below the modulus");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the block busy");

	a_mul_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while still working");

	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_RED_WAIT || state_q == ST_SQ_WAIT ||
			state_q == ST_MUL_WAIT))
		else $error("multiplier finished outside a waiting state");

endmodule
